// ----- src/hmet_pkg.sv -----
`default_nettype none
package hmet_pkg;

  // Request modes
  localparam logic [1:0] MODE_ADD = 2'd0;
  localparam logic [1:0] MODE_THR = 2'd1;
  localparam logic [1:0] MODE_CLR = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FEW  = 2'd1;
  localparam logic [1:0] ST_DROP = 2'd2;

  // Operand selects of the shared log2 unit
  localparam logic [1:0] LSRC_CNT = 2'd0;
  localparam logic [1:0] LSRC_C1  = 2'd1;
  localparam logic [1:0] LSRC_C2  = 2'd2;

  // Fixed field widths
  localparam int CNT_W  = 32;
  localparam int SMP_W  = 16;
  localparam int STEP_W = 16;

  // Configuration register index
  localparam logic REG_BIN_STEP = 1'b0;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [15:0] sample;
  } in_t;

  typedef struct packed {
    logic signed [17:0] threshold;
    logic [1:0]         status;
    logic [8:0]         occupied_bins;
  } out_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic       latch_in;
    logic       clr_init;
    logic       clr_step;
    logic       div_smp;
    logic       k_ld;
    logic       win;
    logic       add_rd;
    logic       add_wr;
    logic       g_init;
    logic       g_rd;
    logic       g_store;
    logic       g_app;
    logic       g_adv;
    logic       e_init;
    logic       e_init2;
    logic       log_start;
    logic [1:0] log_sel;
    logic       lt1_ld;
    logic       lt2_ld;
    logic       e_rd;
    logic       e_mul;
    logic       div_ent;
    logic       e_acc;
    logic       e_cmp;
    logic       e_upd;
    logic       f_rd;
    logic       f_mul;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic clr_last;
    logic drop;
    logic empty;
    logic cnt_nz;
    logic t_last;
    logic n_few;
    logic j_last;
    logic i_last;
    logic div_done;
    logic log_done;
  } stat_t;

endpackage
`default_nettype wire

// ----- src/hmet_ram.sv -----
`default_nettype none
module hmet_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ----- src/hmet_div.sv -----
`default_nettype none
module hmet_div #(
  parameter int NUM_W   = 54,
  parameter int DEN_W   = 40,
  parameter int SHORT_W = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             short_mode,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo,
  output logic [DEN_W-1:0] rem
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [NUM_W-1:0] num_r;
  logic [DEN_W-1:0] den_r;
  logic [NUM_W-1:0] quo_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W:0]   trial;
  logic             qbit;

  // One restoring step: bring down the next dividend bit and try the subtraction.
  assign trial = {rem_r, num_r[NUM_W-1]};
  assign qbit  = (trial >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        // A short run left-aligns a narrow dividend so fewer steps are needed.
        num_r  <= short_mode ? {num[SHORT_W-1:0], {(NUM_W-SHORT_W){1'b0}}} : num;
        cnt_r  <= short_mode ? CNT_W'(SHORT_W) : CNT_W'(NUM_W);
        den_r  <= den;
        quo_r  <= '0;
        rem_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= qbit ? DEN_W'(trial - {1'b0, den_r}) : DEN_W'(trial);
        quo_r <= {quo_r[NUM_W-2:0], qbit};
        num_r <= {num_r[NUM_W-2:0], 1'b0};
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule
`default_nettype wire

// ----- src/hmet_log.sv -----
`default_nettype none
module hmet_log #(
  parameter int IN_W   = 40,
  parameter int FRAC_W = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [IN_W-1:0]                 din,
  output logic                            done,
  output logic [$clog2(IN_W)+FRAC_W-1:0]  result
);

  localparam int EW   = $clog2(IN_W);
  localparam int IT_W = $clog2(FRAC_W + 1);

  logic              busy_r;
  logic              frac_r;
  logic              done_r;
  logic [IN_W-1:0]   v_r;
  logic [EW-1:0]     e_r;
  logic [31:0]       m_r;
  logic [FRAC_W-1:0] r_r;
  logic [IT_W-1:0]   it_r;
  logic [63:0]       sq;
  logic [32:0]       sqs;

  // Square of the Q1.31 mantissa, truncated to Q2.31 (two integer bits).
  assign sq  = m_r * m_r;
  assign sqs = sq[63:31];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        if (din == '0) begin
          e_r    <= '0;
          r_r    <= '0;
          done_r <= 1'b1;
        end else begin
          v_r    <= din;
          e_r    <= EW'(IN_W - 1);
          frac_r <= 1'b0;
          busy_r <= 1'b1;
        end
      end else if (busy_r) begin
        if (!frac_r) begin
          // Normalise one bit a cycle until the top bit is set.
          if (v_r[IN_W-1]) begin
            m_r    <= v_r[IN_W-1 -: 32];
            frac_r <= 1'b1;
            it_r   <= '0;
          end else begin
            v_r <= {v_r[IN_W-2:0], 1'b0};
            e_r <= e_r - EW'(1);
          end
        end else begin
          // One fraction bit a cycle: a square of two or more gives a one.
          m_r  <= sqs[32] ? sqs[32:1] : sqs[31:0];
          r_r  <= {r_r[FRAC_W-2:0], sqs[32]};
          it_r <= it_r + IT_W'(1);
          if (it_r == IT_W'(FRAC_W - 1)) begin
            busy_r <= 1'b0;
            done_r <= 1'b1;
          end
        end
      end
    end
  end

  assign done   = done_r;
  assign result = {e_r, r_r};

endmodule
`default_nettype wire

// ----- src/hmet_dp.sv -----
`default_nettype none
module hmet_dp #(
  parameter int NBINS         = 256,
  parameter int LOG_FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  hmet_pkg::cmd_t      cmd,
  output hmet_pkg::stat_t     stat,
  input  hmet_pkg::in_t       in_data,
  input  logic [15:0]         step,
  output logic                out_valid,
  output hmet_pkg::out_t      out_data
);

  localparam int SW    = $clog2(NBINS);
  localparam int CW    = $clog2(NBINS + 1);
  localparam int TOT_W = hmet_pkg::CNT_W + SW;
  localparam int EW    = $clog2(TOT_W);
  localparam int LOG_W = EW + LOG_FRAC_BITS;
  localparam int H_W   = LOG_W + 1;
  localparam int PW    = hmet_pkg::CNT_W + LOG_W;
  localparam logic signed [17:0] NB18 = 18'(NBINS);

  // Window state
  logic signed [15:0] sample_r;
  logic signed [15:0] low_r;
  logic signed [15:0] high_r;
  logic               empty_r;
  logic               drop_r;
  logic [SW-1:0]      low_slot_r;
  logic [SW-1:0]      slot_r;
  logic [SW-1:0]      clr_idx_r;
  logic signed [16:0] k_r;

  // Threshold search state
  logic [SW-1:0]      t_r;
  logic [CW-1:0]      span_r;
  logic [CW-1:0]      n_r;
  logic [TOT_W-1:0]   tot_r;
  logic [TOT_W-1:0]   c1_r;
  logic [TOT_W-1:0]   c2_r;
  logic [31:0]        cnt_r;
  logic [SW-1:0]      i_r;
  logic [SW-1:0]      j_r;
  logic [SW-1:0]      bid_r;
  logic [LOG_W-1:0]   lt1_r;
  logic [LOG_W-1:0]   lt2_r;
  logic [H_W-1:0]     h_r;
  logic [H_W-1:0]     best_r;
  logic [PW-1:0]      prod_r;
  logic               out_valid_r;
  hmet_pkg::out_t     out_r;

  // Memory ports
  logic               cnt_we;
  logic [SW-1:0]      cnt_waddr;
  logic [31:0]        cnt_wdata;
  logic               cnt_re;
  logic [31:0]        cnt_rdata;
  logic               nzc_re;
  logic [SW-1:0]      nzc_raddr;
  logic [31:0]        nzc_rdata;
  logic [15:0]        nzb_rdata;
  logic [LOG_W-1:0]   nzl_rdata;
  logic [15:0]        gbin;

  // Unit ports
  logic [15:0]        step_eff;
  logic [15:0]        mag;
  logic               div_done;
  logic [PW-1:0]      div_quo;
  logic [TOT_W-1:0]   div_rem;
  logic [TOT_W-1:0]   div_den;
  logic               j_lo;
  logic               log_done;
  logic [LOG_W-1:0]   log_res;
  logic [TOT_W-1:0]   log_din;

  // Window arithmetic
  logic signed [16:0] q17;
  logic signed [16:0] k_nxt;
  logic signed [17:0] k18;
  logic signed [17:0] low18;
  logic signed [17:0] high18;
  logic signed [17:0] off;
  logic signed [17:0] pos;
  logic [SW-1:0]      wslot;
  logic               below;
  logic               above;
  logic               drop_now;

  // Products
  logic [LOG_W-1:0]   lt_sel;
  logic [LOG_W-1:0]   dlog;
  logic [PW-1:0]      prod;
  logic signed [32:0] thp;

  assign step_eff = (step == '0) ? 16'd1 : step;
  assign mag      = sample_r[15] ? (~sample_r + 16'd1) : sample_r;
  assign j_lo     = (j_r < i_r);

  // Floor division result: round towards minus infinity for negative samples.
  assign q17   = {1'b0, div_quo[15:0]};
  assign k_nxt = sample_r[15] ? (-q17 - 17'(div_rem != '0)) : q17;

  // Window growth and ring slot of the new bin.
  assign k18      = {k_r[16], k_r};
  assign low18    = {{2{low_r[15]}}, low_r};
  assign high18   = {{2{high_r[15]}}, high_r};
  assign below    = (k18 < low18);
  assign above    = (k18 > high18);
  assign drop_now = !empty_r && ((below && (high18 - k18 + 18'sd1 > NB18)) ||
                                 (above && (k18 - low18 + 18'sd1 > NB18)));
  assign off      = k18 - low18;
  assign pos      = $signed({{(18-SW){1'b0}}, low_slot_r}) + off;
  always_comb begin
    if (pos < 18'sd0) begin
      wslot = SW'(pos + NB18);
    end else if (pos >= NB18) begin
      wslot = SW'(pos - NB18);
    end else begin
      wslot = SW'(pos);
    end
  end

  // Entropy term operands.
  assign lt_sel = j_lo ? lt1_r : lt2_r;
  assign dlog   = (lt_sel > nzl_rdata) ? (lt_sel - nzl_rdata) : '0;
  assign prod   = nzc_rdata * dlog;
  assign thp    = $signed(nzb_rdata) * $signed({1'b0, step_eff});
  assign gbin   = low_r + 16'(t_r);

  // Shared divider: sample binning and entropy terms.
  assign div_den = cmd.div_smp ? TOT_W'(step_eff) : (j_lo ? c1_r : c2_r);

  hmet_div #(
    .NUM_W   (PW),
    .DEN_W   (TOT_W),
    .SHORT_W (hmet_pkg::SMP_W)
  ) u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (cmd.div_smp | cmd.div_ent),
    .short_mode (cmd.div_smp),
    .num        (cmd.div_smp ? PW'(mag) : prod_r),
    .den        (div_den),
    .done       (div_done),
    .quo        (div_quo),
    .rem        (div_rem)
  );

  // Shared log2 unit.
  always_comb begin
    unique case (cmd.log_sel)
      hmet_pkg::LSRC_C1: log_din = c1_r;
      hmet_pkg::LSRC_C2: log_din = c2_r;
      default:           log_din = TOT_W'(cnt_rdata);
    endcase
  end

  hmet_log #(
    .IN_W   (TOT_W),
    .FRAC_W (LOG_FRAC_BITS)
  ) u_log (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cmd.log_start),
    .din    (log_din),
    .done   (log_done),
    .result (log_res)
  );

  // Bin counter ring.
  assign cnt_we    = cmd.add_wr | cmd.clr_step;
  assign cnt_waddr = cmd.clr_step ? clr_idx_r : slot_r;
  assign cnt_wdata = cmd.clr_step ? 32'd0 : ((&cnt_rdata) ? cnt_rdata : cnt_rdata + 32'd1);
  assign cnt_re    = cmd.add_rd | cmd.g_rd;

  hmet_ram #(.WIDTH(32), .DEPTH(NBINS)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .re    (cnt_re),
    .raddr (slot_r),
    .rdata (cnt_rdata)
  );

  // Compacted lists of non-zero bins: count, bin index and log2 of count.
  assign nzc_re    = cmd.e_init | cmd.e_rd | cmd.e_cmp;
  assign nzc_raddr = cmd.e_init ? '0 : (cmd.e_cmp ? i_r : j_r);

  hmet_ram #(.WIDTH(32), .DEPTH(NBINS)) u_nzc_ram (
    .clk   (clk),
    .we    (cmd.g_store),
    .waddr (n_r[SW-1:0]),
    .wdata (cnt_rdata),
    .re    (nzc_re),
    .raddr (nzc_raddr),
    .rdata (nzc_rdata)
  );

  hmet_ram #(.WIDTH(16), .DEPTH(NBINS)) u_nzb_ram (
    .clk   (clk),
    .we    (cmd.g_store),
    .waddr (n_r[SW-1:0]),
    .wdata (gbin),
    .re    (cmd.f_rd),
    .raddr (bid_r),
    .rdata (nzb_rdata)
  );

  hmet_ram #(.WIDTH(LOG_W), .DEPTH(NBINS)) u_nzl_ram (
    .clk   (clk),
    .we    (cmd.g_app),
    .waddr (n_r[SW-1:0]),
    .wdata (log_res),
    .re    (cmd.e_rd),
    .raddr (j_r),
    .rdata (nzl_rdata)
  );

  // Window and clearing control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r      <= '0;
      high_r     <= '0;
      empty_r    <= 1'b1;
      drop_r     <= 1'b0;
      low_slot_r <= '0;
      clr_idx_r  <= '0;
    end else begin
      if (cmd.clr_init) begin
        low_r      <= '0;
        high_r     <= '0;
        empty_r    <= 1'b1;
        drop_r     <= 1'b0;
        low_slot_r <= '0;
        clr_idx_r  <= '0;
      end
      if (cmd.clr_step) begin
        clr_idx_r <= clr_idx_r + SW'(1);
      end
      if (cmd.win) begin
        if (empty_r) begin
          low_r      <= k_r[15:0];
          high_r     <= k_r[15:0];
          empty_r    <= 1'b0;
          low_slot_r <= '0;
        end else if (drop_now) begin
          drop_r <= 1'b1;
        end else if (below) begin
          low_r      <= k_r[15:0];
          low_slot_r <= wslot;
        end else if (above) begin
          high_r <= k_r[15:0];
        end
      end
    end
  end

  // Sample path and search registers.
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      sample_r <= in_data.sample;
    end
    if (cmd.k_ld) begin
      k_r <= k_nxt;
    end
    if (cmd.win) begin
      slot_r <= empty_r ? '0 : wslot;
    end
    if (cmd.g_init) begin
      t_r    <= '0;
      n_r    <= '0;
      tot_r  <= '0;
      slot_r <= low_slot_r;
      span_r <= CW'(high_r - low_r) + CW'(1);
      bid_r  <= '0;
    end
    if (cmd.g_store) begin
      cnt_r <= cnt_rdata;
    end
    if (cmd.g_app) begin
      n_r   <= n_r + CW'(1);
      tot_r <= tot_r + TOT_W'(cnt_r);
    end
    if (cmd.g_adv) begin
      t_r    <= t_r + SW'(1);
      slot_r <= (slot_r == SW'(NBINS - 1)) ? '0 : slot_r + SW'(1);
    end
    if (cmd.e_init) begin
      i_r   <= SW'(1);
      bid_r <= '0;
    end
    if (cmd.e_init2) begin
      c1_r <= TOT_W'(nzc_rdata);
      c2_r <= tot_r - TOT_W'(nzc_rdata);
    end
    if (cmd.lt1_ld) begin
      lt1_r <= log_res;
    end
    if (cmd.lt2_ld) begin
      lt2_r <= log_res;
      h_r   <= '0;
      j_r   <= '0;
    end
    if (cmd.e_mul) begin
      prod_r <= prod;
    end
    if (cmd.e_acc) begin
      h_r <= h_r + H_W'(div_quo[LOG_W-1:0]);
      j_r <= j_r + SW'(1);
    end
    if (cmd.e_cmp) begin
      // The first split always sets the best; later ones only when strictly greater.
      if ((i_r == SW'(1)) || (h_r > best_r)) begin
        best_r <= h_r;
        bid_r  <= i_r - SW'(1);
      end
    end
    if (cmd.e_upd) begin
      c1_r <= c1_r + TOT_W'(nzc_rdata);
      c2_r <= c2_r - TOT_W'(nzc_rdata);
      i_r  <= i_r + SW'(1);
    end
    if (cmd.f_mul) begin
      out_r.threshold     <= (n_r == '0) ? 18'sd0 : thp[17:0];
      out_r.status        <= (n_r < CW'(2)) ? hmet_pkg::ST_FEW :
                             (drop_r ? hmet_pkg::ST_DROP : hmet_pkg::ST_OK);
      out_r.occupied_bins <= 9'(n_r);
    end
  end

  // Result strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.f_mul;
    end
  end

  assign stat.clr_last = (clr_idx_r == SW'(NBINS - 1));
  assign stat.drop     = drop_now;
  assign stat.empty    = empty_r;
  assign stat.cnt_nz   = (cnt_rdata != '0);
  assign stat.t_last   = (CW'(t_r) == span_r - CW'(1));
  assign stat.n_few    = (n_r < CW'(2));
  assign stat.j_last   = (CW'(j_r) == n_r - CW'(1));
  assign stat.i_last   = (CW'(i_r) == n_r - CW'(1));
  assign stat.div_done = div_done;
  assign stat.log_done = log_done;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

// ----- src/hmet_ctrl.sv -----
`default_nettype none
module hmet_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [1:0]      mode,
  input  hmet_pkg::stat_t stat,
  output hmet_pkg::cmd_t  cmd,
  output logic            busy
);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_CLR    = 5'd1;
  localparam logic [4:0] S_DIV0   = 5'd2;
  localparam logic [4:0] S_DIVW   = 5'd3;
  localparam logic [4:0] S_WIN    = 5'd4;
  localparam logic [4:0] S_ARD    = 5'd5;
  localparam logic [4:0] S_AWR    = 5'd6;
  localparam logic [4:0] S_GINIT  = 5'd7;
  localparam logic [4:0] S_GRD    = 5'd8;
  localparam logic [4:0] S_GCHK   = 5'd9;
  localparam logic [4:0] S_GLOG   = 5'd10;
  localparam logic [4:0] S_EINIT  = 5'd11;
  localparam logic [4:0] S_EINIT2 = 5'd12;
  localparam logic [4:0] S_L1     = 5'd13;
  localparam logic [4:0] S_L1W    = 5'd14;
  localparam logic [4:0] S_L2     = 5'd15;
  localparam logic [4:0] S_L2W    = 5'd16;
  localparam logic [4:0] S_ERD    = 5'd17;
  localparam logic [4:0] S_EMUL   = 5'd18;
  localparam logic [4:0] S_EDIV   = 5'd19;
  localparam logic [4:0] S_EDIVW  = 5'd20;
  localparam logic [4:0] S_ECMP   = 5'd21;
  localparam logic [4:0] S_EUPD   = 5'd22;
  localparam logic [4:0] S_FRD    = 5'd23;
  localparam logic [4:0] S_FMUL   = 5'd24;

  logic [4:0] state_r;
  logic [4:0] state_nxt;

  // Sequencer: one state per step of each request mode.
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.latch_in = 1'b1;
          unique case (mode)
            hmet_pkg::MODE_ADD: state_nxt = S_DIV0;
            hmet_pkg::MODE_THR: state_nxt = S_GINIT;
            hmet_pkg::MODE_CLR: begin
              cmd.clr_init = 1'b1;
              state_nxt    = S_CLR;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      // Adding a sample: bin index, window update, counter increment.
      S_DIV0: begin
        cmd.div_smp = 1'b1;
        state_nxt   = S_DIVW;
      end
      S_DIVW: begin
        if (stat.div_done) begin
          cmd.k_ld  = 1'b1;
          state_nxt = S_WIN;
        end
      end
      S_WIN: begin
        cmd.win   = 1'b1;
        state_nxt = stat.drop ? S_IDLE : S_ARD;
      end
      S_ARD: begin
        cmd.add_rd = 1'b1;
        state_nxt  = S_AWR;
      end
      S_AWR: begin
        cmd.add_wr = 1'b1;
        state_nxt  = S_IDLE;
      end
      // Gathering the non-zero bins of the window.
      S_GINIT: begin
        cmd.g_init = 1'b1;
        state_nxt  = stat.empty ? S_FRD : S_GRD;
      end
      S_GRD: begin
        cmd.g_rd  = 1'b1;
        state_nxt = S_GCHK;
      end
      S_GCHK: begin
        if (stat.cnt_nz) begin
          cmd.g_store   = 1'b1;
          cmd.log_start = 1'b1;
          cmd.log_sel   = hmet_pkg::LSRC_CNT;
          state_nxt     = S_GLOG;
        end else begin
          cmd.g_adv = 1'b1;
          state_nxt = stat.t_last ? S_EINIT : S_GRD;
        end
      end
      S_GLOG: begin
        if (stat.log_done) begin
          cmd.g_app = 1'b1;
          cmd.g_adv = 1'b1;
          state_nxt = stat.t_last ? S_EINIT : S_GRD;
        end
      end
      // Entropy search over every split.
      S_EINIT: begin
        if (stat.n_few) begin
          state_nxt = S_FRD;
        end else begin
          cmd.e_init = 1'b1;
          state_nxt  = S_EINIT2;
        end
      end
      S_EINIT2: begin
        cmd.e_init2 = 1'b1;
        state_nxt   = S_L1;
      end
      S_L1: begin
        cmd.log_start = 1'b1;
        cmd.log_sel   = hmet_pkg::LSRC_C1;
        state_nxt     = S_L1W;
      end
      S_L1W: begin
        if (stat.log_done) begin
          cmd.lt1_ld = 1'b1;
          state_nxt  = S_L2;
        end
      end
      S_L2: begin
        cmd.log_start = 1'b1;
        cmd.log_sel   = hmet_pkg::LSRC_C2;
        state_nxt     = S_L2W;
      end
      S_L2W: begin
        if (stat.log_done) begin
          cmd.lt2_ld = 1'b1;
          state_nxt  = S_ERD;
        end
      end
      S_ERD: begin
        cmd.e_rd  = 1'b1;
        state_nxt = S_EMUL;
      end
      S_EMUL: begin
        cmd.e_mul = 1'b1;
        state_nxt = S_EDIV;
      end
      S_EDIV: begin
        cmd.div_ent = 1'b1;
        state_nxt   = S_EDIVW;
      end
      S_EDIVW: begin
        if (stat.div_done) begin
          cmd.e_acc = 1'b1;
          state_nxt = stat.j_last ? S_ECMP : S_ERD;
        end
      end
      S_ECMP: begin
        cmd.e_cmp = 1'b1;
        state_nxt = S_EUPD;
      end
      S_EUPD: begin
        cmd.e_upd = 1'b1;
        state_nxt = stat.i_last ? S_FRD : S_L1;
      end
      // Threshold of the chosen bin.
      S_FRD: begin
        cmd.f_rd  = 1'b1;
        state_nxt = S_FMUL;
      end
      S_FMUL: begin
        cmd.f_mul = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // The counter ring is swept clear straight after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule
`default_nettype wire

// ----- src/histogram_max_entropy_threshold_core.sv -----
// Channel  Handshake                      Payload
// request  start, accepted when !busy     in_data  (mode, sample)
// result   out_valid, one-cycle strobe    out_data (threshold, status, occupied_bins)
// config   APB write, pready tied high    pwdata[15:0] -> bin_step at address 0
//
// Adding a sample runs the divider in short mode on the 16-bit sample magnitude, then
// updates the window and increments the bin counter; a dropped sample skips the counter.
// Clearing zeroes one counter per cycle; the same sweep runs after reset, with busy high.
// A threshold request gathers the non-zero bins of the window, then searches every split
// with the shared bit-serial divider (PW = 32 + LOG_W dividend bits per entropy term).
// Results cannot be held off.
`default_nettype none
module histogram_max_entropy_threshold_core #(
  parameter int NBINS         = 256,
  parameter int LOG_FRAC_BITS = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  hmet_pkg::in_t  in_data,
  output logic           out_valid,
  output hmet_pkg::out_t out_data,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [2:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);

  hmet_pkg::cmd_t  cmd;
  hmet_pkg::stat_t stat;
  logic [15:0]     step_r;

  // Configuration register: bin width.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= 16'd1;
    end else if (psel && penable && pwrite && (paddr[2] == hmet_pkg::REG_BIN_STEP)) begin
      step_r <= pwdata[15:0];
    end
  end

  assign prdata = (paddr[2] == hmet_pkg::REG_BIN_STEP) ? {16'd0, step_r} : 32'd0;
  assign pready = 1'b1;

  hmet_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .mode  (in_data.mode),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  hmet_dp #(
    .NBINS         (NBINS),
    .LOG_FRAC_BITS (LOG_FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_data),
    .step      (step_r),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
